FILE: rtl/pcs_pkg.sv
`default_nettype none

package pcs_pkg;

  localparam int IN_W    = 12;
  localparam int DATA_W  = 16;
  localparam int E_W     = IN_W + 1;
  localparam int NUM_CFG = 6;

  // Fixed scale divisor for the out_max / 80000 output scaling. The divisor is
  // 2^7 * 625: the power of two is shifted off, and the odd part is removed by a
  // reciprocal multiplication that is exact for dividends below 2^26.
  localparam int SCALE_DIVISOR = 80000;
  localparam int SCALE_SHIFT   = 7;
  localparam int SCALE_ODD     = SCALE_DIVISOR >> SCALE_SHIFT;
  localparam int QUO_X_W       = 26;
  localparam int RCP_SHIFT     = 36;
  localparam logic [26:0] RCP_MULT =
    27'(((64'd1 << RCP_SHIFT) + 64'(SCALE_ODD) - 64'd1) / 64'(SCALE_ODD));

  // Products at or above this magnitude give quotients beyond 16 bits, which the
  // output clamp removes anyway.
  localparam longint SCALE_SAT = longint'(SCALE_DIVISOR) << 16;

  typedef enum logic [2:0] {
    REG_SAMPLE_PERIOD = 3'd0,
    REG_PROP_GAIN     = 3'd1,
    REG_INTEG_GAIN    = 3'd2,
    REG_OUT_MAX       = 3'd3,
    REG_OUT_MIN       = 3'd4,
    REG_MAX_SLOPE     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        [DATA_W-1:0] sample_period;
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] out_max;
    logic signed [DATA_W-1:0] out_min;
    logic        [DATA_W-1:0] max_slope;
  } cfg_t;

  // Datapath operations issued by the sequencer, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_E,
    OP_ACC,
    OP_MUL_I,
    OP_SUM,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_COMB,
    OP_RCP_LO,
    OP_RCP_HI,
    OP_QUO,
    OP_FIN
  } dp_op_t;

endpackage

`default_nettype wire

FILE: rtl/pcs_ctrl.sv
`default_nettype none

module pcs_ctrl import pcs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_tvalid,
  output logic   in_tready,
  output logic   out_tvalid,
  input  logic   out_tready,
  input  logic   cfg_valid,
  output logic   cfg_ready,
  output dp_op_t dp_op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_E,
    S_ACC,
    S_MUL_I,
    S_SUM,
    S_MUL_LO,
    S_MUL_HI,
    S_COMB,
    S_RCP_LO,
    S_RCP_HI,
    S_QUO,
    S_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Register writes are only taken between items and win over a new input.
  assign cfg_ready  = (state_r == S_IDLE);
  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    dp_op         = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && !cfg_valid) begin
          dp_op     = OP_LOAD;
          state_nxt = S_MUL_E;
        end
      end
      S_MUL_E: begin
        dp_op     = OP_MUL_E;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        dp_op     = OP_ACC;
        state_nxt = S_MUL_I;
      end
      S_MUL_I: begin
        dp_op     = OP_MUL_I;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        dp_op     = OP_SUM;
        state_nxt = S_MUL_LO;
      end
      S_MUL_LO: begin
        dp_op     = OP_MUL_LO;
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        dp_op     = OP_MUL_HI;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        dp_op     = OP_COMB;
        state_nxt = S_RCP_LO;
      end
      S_RCP_LO: begin
        dp_op     = OP_RCP_LO;
        state_nxt = S_RCP_HI;
      end
      S_RCP_HI: begin
        dp_op     = OP_RCP_HI;
        state_nxt = S_QUO;
      end
      S_QUO: begin
        dp_op     = OP_QUO;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // The result register may only be reloaded once its transaction is done.
        if (!out_valid_r || out_tready) begin
          dp_op         = OP_FIN;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_fin_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_op == OP_FIN) |=> out_valid_r)
    else $error("result register not marked valid after finishing an item");

  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_op == OP_FIN) |-> (!out_valid_r || out_tready))
    else $error("result overwritten while previous transaction pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("sequencer still idle after accepting an item");

  a_quo_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QUO) |=> (state_r == S_FIN))
    else $error("quotient step not followed by the finishing step");

endmodule

`default_nettype wire

FILE: rtl/pcs_datapath.sv
`default_nettype none

module pcs_datapath import pcs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_op_t                   dp_op,
  input  cfg_t                     cfg,
  input  logic                     clear,
  input  logic        [IN_W-1:0]   set_point,
  input  logic        [IN_W-1:0]   measured_value,
  output logic signed [DATA_W-1:0] drive
);

  localparam logic [15:0] RCP_LO = RCP_MULT[15:0];
  localparam logic [10:0] RCP_HI = RCP_MULT[26:16];
  localparam logic signed [57:0] SAT_POS = 58'(SCALE_SAT);
  localparam logic signed [57:0] SAT_NEG = -SAT_POS;

  logic signed [E_W-1:0]    e_r;
  logic signed [49:0]       mul_r;
  logic signed [31:0]       integ_r;
  logic signed [20:0]       p_r;
  logic signed [39:0]       sum_r;
  logic signed [40:0]       lo_r;
  logic                     neg_r;
  logic                     big_r;
  logic        [QUO_X_W-1:0] x_r;
  logic        [25:0]       frac_r;
  logic signed [17:0]       y_r;
  logic signed [DATA_W-1:0] prev_r;
  logic signed [DATA_W-1:0] drive_r;

  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [49:0] mul_p;
  logic signed [41:0] trunc_w;
  logic signed [33:0] acc_w;
  logic signed [31:0] acc_sat;
  logic signed [57:0] prod_w;
  logic signed [57:0] mag_w;
  logic        [37:0] quo_sum;
  logic        [16:0] quo;
  logic signed [17:0] ymag18;
  logic signed [17:0] min18;
  logic signed [17:0] max18;
  logic signed [17:0] y_lo;
  logic signed [17:0] y18;
  logic signed [17:0] prev18;
  logic signed [17:0] slope18;
  logic signed [17:0] delta18;
  logic signed [17:0] slew18;

  // Signed value divided by 256, rounded toward zero.
  function automatic logic signed [41:0] trunc256(input logic signed [49:0] x);
    logic signed [49:0] t;
    t = x + (x[49] ? 50'sd255 : 50'sd0);
    return t[49:8];
  endfunction

  // One shared multiplier; its operands follow the current operation.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (dp_op)
      OP_MUL_E: begin
        mul_a = {{(17-E_W){e_r[E_W-1]}}, e_r};
        mul_b = {17'b0, cfg.sample_period};
      end
      OP_ACC: begin
        mul_a = {cfg.prop_gain[15], cfg.prop_gain};
        mul_b = {{(33-E_W){e_r[E_W-1]}}, e_r};
      end
      OP_MUL_I: begin
        mul_a = {cfg.integ_gain[15], cfg.integ_gain};
        mul_b = {integ_r[31], integ_r};
      end
      OP_MUL_LO: begin
        mul_a = {cfg.out_max[15], cfg.out_max};
        mul_b = {9'b0, sum_r[23:0]};
      end
      OP_MUL_HI: begin
        mul_a = {cfg.out_max[15], cfg.out_max};
        mul_b = {{17{sum_r[39]}}, sum_r[39:24]};
      end
      OP_RCP_LO: begin
        mul_a = {1'b0, RCP_LO};
        mul_b = {{(33-QUO_X_W){1'b0}}, x_r};
      end
      OP_RCP_HI: begin
        mul_a = {6'b0, RCP_HI};
        mul_b = {{(33-QUO_X_W){1'b0}}, x_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign trunc_w = trunc256(mul_r);

  // Integrator update with saturation to the 32-bit signed range.
  assign acc_w = {{2{integ_r[31]}}, integ_r} + {{5{mul_r[28]}}, mul_r[28:0]};
  always_comb begin
    if (acc_w[33:31] == 3'b000 || acc_w[33:31] == 3'b111) begin
      acc_sat = acc_w[31:0];
    end else if (acc_w[33]) begin
      acc_sat = {1'b1, 31'b0};
    end else begin
      acc_sat = {1'b0, {31{1'b1}}};
    end
  end

  // The high partial product is shifted into place above the low one.
  assign prod_w = {{2{mul_r[31]}}, mul_r[31:0], 24'b0} + {{17{lo_r[40]}}, lo_r};
  assign mag_w  = prod_w[57] ? -prod_w : prod_w;

  // The reciprocal product is split at bit 16; the low half only contributes
  // its upper bits, which is exact for the final shift by 36.
  assign quo_sum = mul_r[37:0] + {12'b0, frac_r};
  assign quo     = big_r ? 17'h10000 : {1'b0, quo_sum[35:20]};
  assign ymag18  = {1'b0, quo};

  // Clamp (lower bound first) and slew limit.
  always_comb begin
    min18   = {{2{cfg.out_min[15]}}, cfg.out_min};
    max18   = {{2{cfg.out_max[15]}}, cfg.out_max};
    y_lo    = (y_r < min18) ? min18 : y_r;
    y18     = (y_lo > max18) ? max18 : y_lo;
    prev18  = {{2{prev_r[15]}}, prev_r};
    slope18 = {2'b0, cfg.max_slope};
    delta18 = y18 - prev18;
    if (delta18 > slope18) begin
      slew18 = prev18 + slope18;
    end else if (delta18 < -slope18) begin
      slew18 = prev18 - slope18;
    end else begin
      slew18 = y18;
    end
  end

  always_ff @(posedge clk) begin
    case (dp_op)
      OP_LOAD: begin
        e_r <= $signed({1'b0, set_point}) - $signed({1'b0, measured_value});
      end
      OP_MUL_E, OP_ACC, OP_MUL_LO, OP_RCP_LO: begin
        mul_r <= mul_p;
      end
      OP_MUL_I: begin
        mul_r <= mul_p;
        p_r   <= trunc_w[20:0];
      end
      OP_SUM: begin
        sum_r <= {{19{p_r[20]}}, p_r} + trunc_w[39:0];
      end
      OP_MUL_HI: begin
        mul_r <= mul_p;
        lo_r  <= mul_r[40:0];
      end
      OP_COMB: begin
        neg_r <= prod_w[57];
        big_r <= (prod_w >= SAT_POS) || (prod_w <= SAT_NEG);
        x_r   <= mag_w[QUO_X_W+SCALE_SHIFT-1:SCALE_SHIFT];
      end
      OP_RCP_HI: begin
        mul_r  <= mul_p;
        frac_r <= mul_r[41:16];
      end
      OP_QUO: begin
        y_r <= neg_r ? -ymag18 : ymag18;
      end
      OP_FIN: begin
        drive_r <= slew18[15:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
    end else if (clear) begin
      // A write to a listed register restarts the loop from rest.
      integ_r <= '0;
      prev_r  <= '0;
    end else begin
      if (dp_op == OP_ACC) begin
        integ_r <= acc_sat;
      end
      if (dp_op == OP_FIN) begin
        prev_r <= slew18[15:0];
      end
    end
  end

  assign drive = drive_r;

  a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_op == OP_QUO && !big_r) |-> (quo_sum[37:36] == 2'b00))
    else $error("reciprocal quotient exceeded 16 bits");

endmodule

`default_nettype wire

FILE: rtl/pi_controller_clamp_slew_unit.sv
`default_nettype none

// PI controller with output clamp and slew limit. Each transaction on the in_
// stream carries a set point and a measured sample and yields exactly one drive
// value on the out_ stream. A new item is accepted only after the last one is
// through, and its result is registered and offered by the finishing step: a
// single shared 17x33 multiplier forms seven products in sequence, three for the
// controller terms, two for the out_max product and two for a reciprocal divide
// by 80000. Quotients beyond 16 bits saturate, since the clamp removes them
// anyway. The result sits in an output register, so a new item is accepted while
// the previous result is still waiting to be taken; the next item then holds in
// its last step until that transaction is done. cfg_ready is high only while no
// item is being processed, and a register write takes priority over an input
// transaction in the same cycle. A write to a listed register clears the
// integrator and the previous drive value.

module pi_controller_clamp_slew_unit import pcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [11:0] set_point, [23:12] measured_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] drive
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t   cfg_r;
  logic   cfg_wr;
  logic   clear;
  dp_op_t dp_op;
  logic signed [DATA_W-1:0] drive;

  assign cfg_wr    = cfg_valid & cfg_ready;

  always_comb begin
    clear = 1'b0;
    if (cfg_wr) begin
      case (cfg_index)
        REG_SAMPLE_PERIOD, REG_PROP_GAIN, REG_INTEG_GAIN,
        REG_OUT_MAX, REG_OUT_MIN, REG_MAX_SLOPE: clear = 1'b1;
        default: clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_period <= 16'd1;
      cfg_r.prop_gain     <= 16'sd256;
      cfg_r.integ_gain    <= 16'sd0;
      cfg_r.out_max       <= 16'sd4095;
      cfg_r.out_min       <= 16'sd0;
      cfg_r.max_slope     <= 16'hFFFF;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_SAMPLE_PERIOD: cfg_r.sample_period <= cfg_data;
        REG_PROP_GAIN:     cfg_r.prop_gain     <= cfg_data;
        REG_INTEG_GAIN:    cfg_r.integ_gain    <= cfg_data;
        REG_OUT_MAX:       cfg_r.out_max       <= cfg_data;
        REG_OUT_MIN:       cfg_r.out_min       <= cfg_data;
        REG_MAX_SLOPE:     cfg_r.max_slope     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .dp_op      (dp_op)
  );

  pcs_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .dp_op          (dp_op),
    .cfg            (cfg_r),
    .clear          (clear),
    .set_point      (in_tdata[11:0]),
    .measured_value (in_tdata[23:12]),
    .drive          (drive)
  );

  assign out_tdata = drive;

endmodule

`default_nettype wire

FILE: dv/tb_pi_controller_clamp_slew_unit.sv
`timescale 1ns / 100ps

module tb_pi_controller_clamp_slew_unit;
  import pcs_pkg::*;

  localparam int ITEM_LATENCY    = 12;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int MAX_REPORTS     = 10;

  // Indexes that the block decodes but does not implement.
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  localparam longint INTEG_MAX = 64'sd2147483647;
  localparam longint INTEG_MIN = -64'sd2147483648;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  pi_controller_clamp_slew_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  typedef struct packed {
    bit          is_write;
    logic [2:0]  idx;
    logic [15:0] data;
    logic [11:0] set_point;
    logic [11:0] measured;
    bit          typed;
    logic [15:0] drive;
  } step_row_t;

  step_row_t directed_rows[$];
  logic signed [15:0] expected_drive[$];

  // Controller state and register copy, at reset values.
  logic        [15:0] pi_period   = 16'd1;
  logic signed [15:0] pi_kp       = 16'sd256;
  logic signed [15:0] pi_ki       = 16'sd0;
  logic signed [15:0] pi_out_max  = 16'sd4095;
  logic signed [15:0] pi_out_min  = 16'sd0;
  logic        [15:0] pi_slope    = 16'hffff;
  logic signed [31:0] pi_integ    = '0;
  logic signed [15:0] pi_prev     = '0;

  int                 mismatches  = 0;
  int                 cycle_count = 0;
  int                 stall_left  = 0;
  int                 ready_roll;
  bit                 fast_mode   = 1'b0;
  logic signed [15:0] want_drive;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void pi_reg_write(logic [2:0] idx, logic [15:0] data);
    case (idx)
      REG_SAMPLE_PERIOD: pi_period  = data;
      REG_PROP_GAIN:     pi_kp      = data;
      REG_INTEG_GAIN:    pi_ki      = data;
      REG_OUT_MAX:       pi_out_max = data;
      REG_OUT_MIN:       pi_out_min = data;
      REG_MAX_SLOPE:     pi_slope   = data;
      default:           return;
    endcase
    pi_integ = '0;
    pi_prev  = '0;
  endfunction

  function automatic logic signed [15:0] predict_drive(logic [11:0] sp, logic [11:0] mv);
    longint err, acc, p_term, i_term, y, slope, delta;
    err = longint'(sp) - longint'(mv);
    acc = longint'(pi_integ) + err * longint'(pi_period);
    if (acc > INTEG_MAX) acc = INTEG_MAX;
    if (acc < INTEG_MIN) acc = INTEG_MIN;
    pi_integ = acc[31:0];
    p_term = (longint'(pi_kp) * err) / 256;
    i_term = (longint'(pi_ki) * acc) / 256;
    y = (longint'(pi_out_max) * (p_term + i_term)) / SCALE_DIVISOR;
    // Lower bound first, so crossed bounds end at out_max.
    if (y < longint'(pi_out_min)) y = pi_out_min;
    if (y > longint'(pi_out_max)) y = pi_out_max;
    slope = longint'(pi_slope);
    delta = y - longint'(pi_prev);
    if (delta > slope) y = longint'(pi_prev) + slope;
    else if (delta < -slope) y = longint'(pi_prev) - slope;
    pi_prev = y[15:0];
    return y[15:0];
  endfunction

  function automatic int pick_gap();
    int r;
    if (fast_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_reg_value(logic [2:0] idx);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      case ($urandom_range(0, 4))
        0:       return 16'h0000;
        1:       return 16'h0001;
        2:       return 16'h7fff;
        3:       return 16'h8000;
        default: return 16'hffff;
      endcase
    end
    if (r < 60) begin
      if (idx == REG_OUT_MAX) return 16'($urandom_range(0, 32767));
      v = $urandom_range(0, 600);
      if ((idx == REG_PROP_GAIN || idx == REG_INTEG_GAIN || idx == REG_OUT_MIN) &&
          $urandom_range(0, 1) == 1)
        return 16'(-v);
      return 16'(v);
    end
    return 16'($urandom);
  endfunction

  function automatic void add_sample(logic [11:0] sp, logic [11:0] mv);
    directed_rows.push_back('{1'b0, 3'd0, 16'd0, sp, mv, 1'b0, 16'd0});
  endfunction

  function automatic void add_checked(logic [11:0] sp, logic [11:0] mv, logic [15:0] drive);
    directed_rows.push_back('{1'b0, 3'd0, 16'd0, sp, mv, 1'b1, drive});
  endfunction

  function automatic void add_write(logic [2:0] idx, logic [15:0] data);
    directed_rows.push_back('{1'b1, idx, data, 12'd0, 12'd0, 1'b0, 16'd0});
  endfunction

  // One register transaction; the predictor sees it at the accepting edge.
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    pi_reg_write(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (ITEM_LATENCY + 8) @(posedge clk);
  endtask

  task automatic send_sample(logic [11:0] sp, logic [11:0] mv, bit typed,
                             logic [15:0] drive);
    int gap;
    logic signed [15:0] predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 24'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {mv, sp};
    do @(posedge clk); while (!in_tready);
    predicted = predict_drive(sp, mv);
    expected_drive.push_back(typed ? drive : predicted);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (fast_mode) begin
      out_tready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 65) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left = (ready_roll < 93) ? $urandom_range(0, 3) : $urandom_range(10, 50);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_drive.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected drive transaction: got %0d", $signed(out_tdata));
      end else begin
        want_drive = expected_drive.pop_front();
        if (out_tdata !== want_drive) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("drive mismatch: expected %0d, got %0d", want_drive,
                     $signed(out_tdata));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_pi_controller_clamp_slew_unit: errors");
      $finish;
    end
  end

  initial begin
    bit          prev_write;
    int          ph;
    int          n;
    int          k;
    int          r;
    int          hold_sp;
    int          mv_i;
    logic [11:0] sp;
    logic [11:0] mv;

    // Reset values: full-scale error in both directions.
    add_checked(12'd4095, 12'd0, 16'd209);
    add_checked(12'd0, 12'd4095, 16'd0);
    // A zero slew limit pins the drive at the previous value.
    add_write(REG_MAX_SLOPE, 16'd0);
    add_checked(12'd4095, 12'd0, 16'd0);
    // Widest gains and bounds; the integrator runs into its positive limit.
    add_write(REG_SAMPLE_PERIOD, 16'hffff);
    add_write(REG_PROP_GAIN, 16'h7fff);
    add_write(REG_INTEG_GAIN, 16'h8000);
    add_write(REG_OUT_MAX, 16'h7fff);
    add_write(REG_OUT_MIN, 16'h8000);
    add_write(REG_MAX_SLOPE, 16'd10);
    repeat (9) add_sample(12'd4095, 12'd0);
    // Opposite gain extremes; the integrator runs into its negative limit.
    add_write(REG_PROP_GAIN, 16'h8000);
    add_write(REG_INTEG_GAIN, 16'h7fff);
    repeat (9) add_sample(12'd0, 12'd4095);
    // Unlisted indexes must leave the state alone.
    add_write(REG_SPARE_6, 16'hffff);
    add_write(REG_SPARE_7, 16'h0000);
    add_sample(12'd2048, 12'd2048);
    // Crossed clamp bounds resolve to the upper bound.
    add_write(REG_OUT_MIN, 16'd100);
    add_write(REG_OUT_MAX, 16'hff9c);
    add_write(REG_MAX_SLOPE, 16'hffff);
    add_checked(12'd1000, 12'd3000, 16'hff9c);
    // A zero sample period holds the integrator.
    add_write(REG_SAMPLE_PERIOD, 16'd0);
    add_write(REG_OUT_MAX, 16'h7fff);
    add_write(REG_OUT_MIN, 16'h8000);
    add_write(REG_INTEG_GAIN, 16'h0100);
    add_sample(12'd4095, 12'd0);
    add_sample(12'd0, 12'd4095);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_write = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        if (!prev_write) settle();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_sample(directed_rows[i].set_point, directed_rows[i].measured,
                    directed_rows[i].typed, directed_rows[i].drive);
      end
      prev_write = directed_rows[i].is_write;
    end

    hold_sp = 2048;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      fast_mode = (ph == 2);
      for (k = 0; k < NUM_CFG; k++)
        if ($urandom_range(0, 9) < 6) write_reg(3'(k), pick_reg_value(3'(k)));
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          sp = 12'($urandom);
          mv = 12'($urandom);
        end else if (r < 85) begin
          // Tracking near a held set point keeps the loop out of the clamps.
          if ($urandom_range(0, 19) == 0) hold_sp = $urandom_range(0, 4095);
          mv_i = hold_sp + $urandom_range(0, 64) - 32;
          if (mv_i < 0) mv_i = 0;
          if (mv_i > 4095) mv_i = 4095;
          sp = 12'(hold_sp);
          mv = 12'(mv_i);
        end else begin
          sp = $urandom_range(0, 1) ? 12'hfff : 12'h000;
          mv = $urandom_range(0, 1) ? 12'hfff : 12'h000;
        end
        send_sample(sp, mv, 1'b0, 16'd0);
      end
    end
    fast_mode = 1'b0;

    settle();
    repeat (2 * ITEM_LATENCY) @(posedge clk);
    if (mismatches == 0)
      $display("tb_pi_controller_clamp_slew_unit: clean");
    else
      $display("tb_pi_controller_clamp_slew_unit: errors");
    $finish;
  end

endmodule
